### hw/rtl/bfs_pkg.sv
// Shared types and constants of the block-variance focus selector.
package bfs_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned SUM_W      = 18;
  localparam int unsigned SQ_W       = 27;
  localparam int unsigned TILE_IDX_W = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CFG_TILE_W = 6;
  localparam int unsigned CFG_DIM_W  = 11;

  // Queue entry fields are sized for the largest supported frame and tile.
  localparam int unsigned COL_MAX_W  = 12;
  localparam int unsigned ROW_MAX_W  = 12;
  localparam int unsigned N_MAX_W    = 13;

  localparam int unsigned PROD_W     = (N_MAX_W + SQ_W > 2 * SUM_W) ?
                                       N_MAX_W + SQ_W : 2 * SUM_W;
  localparam int unsigned ACC_W      = 2 * (SUM_W + SQ_W);

  localparam logic [CFG_TILE_W-1:0] TILE_SIZE_RST    = CFG_TILE_W'(10);
  localparam logic [CFG_DIM_W-1:0]  IMAGE_WIDTH_RST  = CFG_DIM_W'(640);
  localparam logic [CFG_DIM_W-1:0]  IMAGE_HEIGHT_RST = CFG_DIM_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILE_SIZE    = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } bfs_cfg_idx_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ACC,
    BK_MUL,
    BK_SUB,
    BK_OUT
  } bfs_back_state_e;

  typedef struct packed {
    logic [PIX_W-1:0]     pixel_first;
    logic [PIX_W-1:0]     pixel_second;
    logic [COL_MAX_W-1:0] col;
    logic [ROW_MAX_W-1:0] row;
    logic [N_MAX_W-1:0]   n;
    logic                 load;
    logic                 tile_end;
    logic                 frame_done;
  } bfs_entry_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum_first;
    logic [SQ_W-1:0]  sumsq_first;
    logic [SUM_W-1:0] sum_second;
    logic [SQ_W-1:0]  sumsq_second;
  } bfs_acc_t;

  typedef struct packed {
    logic [TILE_IDX_W-1:0] tile_col;
    logic [TILE_IDX_W-1:0] tile_row;
    logic                  pick_second;
    logic                  frame_done;
  } bfs_result_t;

endpackage

### hw/rtl/bfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bfs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/bfs_front.sv
// Front end: configuration registers, raster and tile counters, item classification.
module bfs_front #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned MAX_TILE   = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [bfs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bfs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [bfs_pkg::PIX_W-1:0]        pixel_first_i,
  input  logic [bfs_pkg::PIX_W-1:0]        pixel_second_i,
  output logic                             push_valid_o,
  input  logic                             push_ready_i,
  output bfs_pkg::bfs_entry_t              entry_o
);

  localparam int unsigned XW  = $clog2(MAX_WIDTH);
  localparam int unsigned YW  = $clog2(MAX_HEIGHT);
  localparam int unsigned WCW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HCW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned TXW = $clog2(MAX_TILE);
  localparam int unsigned TCW = $clog2(MAX_TILE + 1);

  logic [bfs_pkg::CFG_TILE_W-1:0] tile_size_q;
  logic [bfs_pkg::CFG_DIM_W-1:0]  image_width_q;
  logic [bfs_pkg::CFG_DIM_W-1:0]  image_height_q;

  logic [XW-1:0]  pixel_x_q, pixel_x_d;
  logic [YW-1:0]  pixel_y_q, pixel_y_d;
  logic [TXW-1:0] x_in_tile_q, x_in_tile_d;
  logic [TXW-1:0] y_in_tile_q, y_in_tile_d;
  logic [XW-1:0]  col_q, col_d;
  logic [YW-1:0]  row_q, row_d;

  logic [TCW-1:0]   ts_lim;
  logic [WCW-1:0]   w_lim;
  logic [HCW-1:0]   h_lim;
  logic [TCW-1:0]   x_run, y_run;
  logic [2*TCW-1:0] n_prod;
  logic             row_end, col_end, tile_x_end, tile_y_end;
  logic             accept;

  // Saturate the register values to the supported range.
  always_comb begin
    priority if (tile_size_q == '0) begin
      ts_lim = TCW'(1);
    end else if (tile_size_q > MAX_TILE) begin
      ts_lim = TCW'(MAX_TILE);
    end else begin
      ts_lim = TCW'(tile_size_q);
    end
    priority if (image_width_q == '0) begin
      w_lim = WCW'(1);
    end else if (image_width_q > MAX_WIDTH) begin
      w_lim = WCW'(MAX_WIDTH);
    end else begin
      w_lim = WCW'(image_width_q);
    end
    priority if (image_height_q == '0) begin
      h_lim = HCW'(1);
    end else if (image_height_q > MAX_HEIGHT) begin
      h_lim = HCW'(MAX_HEIGHT);
    end else begin
      h_lim = HCW'(image_height_q);
    end
  end

  assign x_run      = TCW'(x_in_tile_q) + TCW'(1);
  assign y_run      = TCW'(y_in_tile_q) + TCW'(1);
  assign row_end    = (WCW'(pixel_x_q) + WCW'(1)) >= w_lim;
  assign col_end    = (HCW'(pixel_y_q) + HCW'(1)) >= h_lim;
  assign tile_x_end = row_end || (x_run >= ts_lim);
  assign tile_y_end = col_end || (y_run >= ts_lim);
  assign n_prod     = {{TCW{1'b0}}, x_run} * {{TCW{1'b0}}, y_run};

  // Hold off pixels while a register write restarts the frame.
  assign in_ready_o   = push_ready_i && !cfg_valid_i;
  assign push_valid_o = in_valid_i && !cfg_valid_i;
  assign accept       = in_valid_i && in_ready_o;

  always_comb begin
    entry_o.pixel_first  = pixel_first_i;
    entry_o.pixel_second = pixel_second_i;
    entry_o.col          = bfs_pkg::COL_MAX_W'(col_q);
    entry_o.row          = bfs_pkg::ROW_MAX_W'(row_q);
    entry_o.n            = bfs_pkg::N_MAX_W'(n_prod);
    entry_o.load         = (x_in_tile_q == '0) && (y_in_tile_q == '0);
    entry_o.tile_end     = tile_x_end && tile_y_end;
    entry_o.frame_done   = row_end && col_end;
  end

  // Advance the raster position; restart the frame on any register write.
  always_comb begin
    pixel_x_d   = pixel_x_q;
    pixel_y_d   = pixel_y_q;
    x_in_tile_d = x_in_tile_q;
    y_in_tile_d = y_in_tile_q;
    col_d       = col_q;
    row_d       = row_q;
    priority if (cfg_valid_i) begin
      pixel_x_d   = '0;
      pixel_y_d   = '0;
      x_in_tile_d = '0;
      y_in_tile_d = '0;
      col_d       = '0;
      row_d       = '0;
    end else if (accept) begin
      if (row_end) begin
        pixel_x_d   = '0;
        x_in_tile_d = '0;
        col_d       = '0;
        if (col_end) begin
          pixel_y_d   = '0;
          y_in_tile_d = '0;
          row_d       = '0;
        end else begin
          pixel_y_d = pixel_y_q + YW'(1);
          if (tile_y_end) begin
            y_in_tile_d = '0;
            row_d       = row_q + YW'(1);
          end else begin
            y_in_tile_d = y_in_tile_q + TXW'(1);
          end
        end
      end else begin
        pixel_x_d = pixel_x_q + XW'(1);
        if (tile_x_end) begin
          x_in_tile_d = '0;
          col_d       = col_q + XW'(1);
        end else begin
          x_in_tile_d = x_in_tile_q + TXW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_size_q    <= bfs_pkg::TILE_SIZE_RST;
      image_width_q  <= bfs_pkg::IMAGE_WIDTH_RST;
      image_height_q <= bfs_pkg::IMAGE_HEIGHT_RST;
      pixel_x_q      <= '0;
      pixel_y_q      <= '0;
      x_in_tile_q    <= '0;
      y_in_tile_q    <= '0;
      col_q          <= '0;
      row_q          <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          bfs_pkg::CFG_TILE_SIZE: begin
            tile_size_q <= cfg_data_i[bfs_pkg::CFG_TILE_W-1:0];
          end
          bfs_pkg::CFG_IMAGE_WIDTH: begin
            image_width_q <= cfg_data_i[bfs_pkg::CFG_DIM_W-1:0];
          end
          bfs_pkg::CFG_IMAGE_HEIGHT: begin
            image_height_q <= cfg_data_i[bfs_pkg::CFG_DIM_W-1:0];
          end
          default: begin
          end
        endcase
      end
      pixel_x_q   <= pixel_x_d;
      pixel_y_q   <= pixel_y_d;
      x_in_tile_q <= x_in_tile_d;
      y_in_tile_q <= y_in_tile_d;
      col_q       <= col_d;
      row_q       <= row_d;
    end
  end

endmodule

### hw/rtl/bfs_queue.sv
// Short register queue between the front end and the back end.
module bfs_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  bfs_pkg::bfs_entry_t push_entry_i,
  output logic                pop_valid_o,
  input  logic                pop_i,
  output bfs_pkg::bfs_entry_t pop_entry_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  bfs_pkg::bfs_entry_t slot_q [DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign push_ready_o = count_q != CW'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_entry_o  = slot_q[rptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
      end
      count_q <= count_q + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

### hw/rtl/bfs_back.sv
// Back end: column accumulators in RAM, tile variance compare, result register.
module bfs_back #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  output logic                 pop_o,
  input  bfs_pkg::bfs_entry_t  pop_entry_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bfs_pkg::bfs_result_t result_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  bfs_pkg::bfs_back_state_e state_q, state_d;
  bfs_pkg::bfs_entry_t      cur_q;
  bfs_pkg::bfs_acc_t        acc_rd, acc_new, acc_q;
  bfs_pkg::bfs_result_t     result_q;
  logic [bfs_pkg::ACC_W-1:0]  ram_rdata;
  logic [bfs_pkg::PROD_W-1:0] p1_q, q1_q, p2_q, q2_q;
  logic [bfs_pkg::PROD_W-1:0] v1_q, v2_q;
  logic [2*bfs_pkg::PIX_W-1:0] sq_a, sq_b;
  logic                        ram_we, out_load, out_valid_q;

  bfs_ram #(
    .WIDTH (bfs_pkg::ACC_W),
    .DEPTH (MAX_WIDTH)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(cur_q.col)),
    .wdata_i (acc_new),
    .raddr_i (AW'(pop_entry_i.col)),
    .rdata_o (ram_rdata)
  );

  assign acc_rd = ram_rdata;
  assign sq_a   = cur_q.pixel_first * cur_q.pixel_first;
  assign sq_b   = cur_q.pixel_second * cur_q.pixel_second;

  // Load on the first pixel of a tile, else add to the column sums.
  always_comb begin
    if (cur_q.load) begin
      acc_new.sum_first    = bfs_pkg::SUM_W'(cur_q.pixel_first);
      acc_new.sumsq_first  = bfs_pkg::SQ_W'(sq_a);
      acc_new.sum_second   = bfs_pkg::SUM_W'(cur_q.pixel_second);
      acc_new.sumsq_second = bfs_pkg::SQ_W'(sq_b);
    end else begin
      acc_new.sum_first    = acc_rd.sum_first + bfs_pkg::SUM_W'(cur_q.pixel_first);
      acc_new.sumsq_first  = acc_rd.sumsq_first + bfs_pkg::SQ_W'(sq_a);
      acc_new.sum_second   = acc_rd.sum_second + bfs_pkg::SUM_W'(cur_q.pixel_second);
      acc_new.sumsq_second = acc_rd.sumsq_second + bfs_pkg::SQ_W'(sq_b);
    end
  end

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    ram_we   = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      bfs_pkg::BK_IDLE: begin
        if (pop_valid_i) begin
          pop_o   = 1'b1;
          state_d = bfs_pkg::BK_ACC;
        end
      end
      bfs_pkg::BK_ACC: begin
        ram_we  = 1'b1;
        state_d = cur_q.tile_end ? bfs_pkg::BK_MUL : bfs_pkg::BK_IDLE;
      end
      bfs_pkg::BK_MUL: begin
        state_d = bfs_pkg::BK_SUB;
      end
      bfs_pkg::BK_SUB: begin
        state_d = bfs_pkg::BK_OUT;
      end
      bfs_pkg::BK_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = bfs_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = bfs_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfs_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
    end
  end

  // Datapath registers, each loaded in its own step.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= pop_entry_i;
    end
    if (state_q == bfs_pkg::BK_ACC) begin
      acc_q <= acc_new;
    end
    if (state_q == bfs_pkg::BK_MUL) begin
      p1_q <= bfs_pkg::PROD_W'(cur_q.n) * bfs_pkg::PROD_W'(acc_q.sumsq_first);
      q1_q <= bfs_pkg::PROD_W'(acc_q.sum_first) * bfs_pkg::PROD_W'(acc_q.sum_first);
      p2_q <= bfs_pkg::PROD_W'(cur_q.n) * bfs_pkg::PROD_W'(acc_q.sumsq_second);
      q2_q <= bfs_pkg::PROD_W'(acc_q.sum_second) * bfs_pkg::PROD_W'(acc_q.sum_second);
    end
    if (state_q == bfs_pkg::BK_SUB) begin
      v1_q <= (p1_q >= q1_q) ? p1_q - q1_q : '0;
      v2_q <= (p2_q >= q2_q) ? p2_q - q2_q : '0;
    end
    if (out_load) begin
      result_q.tile_col    <= bfs_pkg::TILE_IDX_W'(cur_q.col);
      result_q.tile_row    <= bfs_pkg::TILE_IDX_W'(cur_q.row);
      result_q.pick_second <= v2_q >= v1_q;
      result_q.frame_done  <= cur_q.frame_done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

### hw/rtl/block_variance_focus_select.sv
// Top level of the block-variance focus selector.
//
// Usage: pixel pairs (first and second image, same raster position) enter on
// the in_valid_i/in_ready_o channel in raster order. The frame is cut into
// square tiles; when the last pixel of a tile is taken, one result leaves on
// out_valid_o/out_ready_i with the tile position, pick_second (second image's
// n*sumsq - sum^2 not below the first's) and frame_done on the frame's last tile.
// Registers are written on cfg_valid_i (cfg_ready_o is always high); any
// write, even to an unused index, restarts the frame at pixel zero, and
// in_ready_o stays low in the cycle of the write.
// Pacing: the back end takes a new pixel only when the read-modify-write of the
// column accumulator RAM for the last one is done; a pixel that closes a tile
// also goes through multiply, subtract and result steps before the next is
// taken. A 2-entry queue lets the input run ahead; a result shows once its pixel
// has passed the queue and these steps, when the back end is free.
// Reset: counters clear, registers go to tile 10, 640 x 480; the accumulator
// RAM needs no clearing since every tile starts by loading it.
// Receiver stall: the result register holds; the back end waits, the queue
// fills and in_ready_o drops.
module block_variance_focus_select #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned MAX_TILE   = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bfs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bfs_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [bfs_pkg::PIX_W-1:0]           pixel_first_i,
  input  logic [bfs_pkg::PIX_W-1:0]           pixel_second_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [bfs_pkg::TILE_IDX_W-1:0]      tile_col_o,
  output logic [bfs_pkg::TILE_IDX_W-1:0]      tile_row_o,
  output logic                                pick_second_o,
  output logic                                frame_done_o
);

  bfs_pkg::bfs_entry_t  push_entry, pop_entry;
  bfs_pkg::bfs_result_t result;
  logic                 push_valid, push_ready, pop_valid, pop;

  assign cfg_ready_o = 1'b1;

  bfs_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_TILE   (MAX_TILE)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_first_i  (pixel_first_i),
    .pixel_second_i (pixel_second_i),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .entry_o        (push_entry)
  );

  bfs_queue #(
    .DEPTH (2)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry)
  );

  bfs_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_entry_i (pop_entry),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign tile_col_o    = result.tile_col;
  assign tile_row_o    = result.tile_row;
  assign pick_second_o = result.pick_second;
  assign frame_done_o  = result.frame_done;

endmodule

### sim/tb.sv
// Self-checking testbench for the block-variance focus selector.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MAX_W   = 1024;
  localparam int unsigned MAX_H   = 1024;
  localparam int unsigned MAX_T   = 32;
  localparam int unsigned DRAIN   = 40;
  localparam logic [bfs_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  // Pixel content styles for one run of stimulus.
  typedef enum int {
    PIX_RANDOM,
    PIX_FIRST_FLAT,
    PIX_BOTH_FLAT,
    PIX_EXTREMES,
    PIX_EQUAL,
    PIX_NEAR
  } pix_style_e;

  class focus_scoreboard;
    logic [bfs_pkg::CFG_TILE_W-1:0] tile_reg;
    logic [bfs_pkg::CFG_DIM_W-1:0]  width_reg;
    logic [bfs_pkg::CFG_DIM_W-1:0]  height_reg;
    logic [bfs_pkg::SUM_W-1:0]      sum_a [MAX_W];
    logic [bfs_pkg::SQ_W-1:0]       sq_a  [MAX_W];
    logic [bfs_pkg::SUM_W-1:0]      sum_b [MAX_W];
    logic [bfs_pkg::SQ_W-1:0]       sq_b  [MAX_W];
    logic [9:0]                     pos_x;
    logic [9:0]                     pos_y;
    logic [4:0]                     x_in;
    logic [4:0]                     y_in;
    bfs_pkg::bfs_result_t           tiles_due[$];
    int                             errors;

    function new();
      tile_reg   = bfs_pkg::TILE_SIZE_RST;
      width_reg  = bfs_pkg::IMAGE_WIDTH_RST;
      height_reg = bfs_pkg::IMAGE_HEIGHT_RST;
      foreach (sum_a[i]) begin
        sum_a[i] = '0;
        sq_a[i]  = '0;
        sum_b[i] = '0;
        sq_b[i]  = '0;
      end
      errors = 0;
      restart();
    endfunction

    function void restart();
      pos_x = '0;
      pos_y = '0;
      x_in  = '0;
      y_in  = '0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
    endfunction

    function void write_reg(logic [bfs_pkg::CFG_IDX_W-1:0] idx,
                            logic [bfs_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        bfs_pkg::CFG_TILE_SIZE:    tile_reg   = data[bfs_pkg::CFG_TILE_W-1:0];
        bfs_pkg::CFG_IMAGE_WIDTH:  width_reg  = data;
        bfs_pkg::CFG_IMAGE_HEIGHT: height_reg = data;
        default: ;
      endcase
      restart();
    endfunction

    function void note_pixel(logic [bfs_pkg::PIX_W-1:0] a, logic [bfs_pkg::PIX_W-1:0] b);
      int unsigned ts, w, h, col, row, n, xi, yi;
      bit row_end, col_end, x_end, y_end;
      longint unsigned p1, q1, p2, q2, v1, v2;
      bfs_pkg::bfs_result_t r;
      ts = clamp(tile_reg, MAX_T);
      w  = clamp(width_reg, MAX_W);
      h  = clamp(height_reg, MAX_H);
      xi = x_in;
      yi = y_in;
      col = int'(pos_x) / ts;
      row = int'(pos_y) / ts;
      if (col >= MAX_W) col = MAX_W - 1;
      row_end = (int'(pos_x) + 1 >= w);
      col_end = (int'(pos_y) + 1 >= h);
      x_end   = row_end || (xi + 1 >= ts);
      y_end   = col_end || (yi + 1 >= ts);

      // First pixel of a tile loads the column sums.
      if (xi == 0 && yi == 0) begin
        sum_a[col] = bfs_pkg::SUM_W'(a);
        sq_a[col]  = bfs_pkg::SQ_W'(int'(a) * int'(a));
        sum_b[col] = bfs_pkg::SUM_W'(b);
        sq_b[col]  = bfs_pkg::SQ_W'(int'(b) * int'(b));
      end else begin
        sum_a[col] = bfs_pkg::SUM_W'(sum_a[col] + a);
        sq_a[col]  = bfs_pkg::SQ_W'(sq_a[col] + int'(a) * int'(a));
        sum_b[col] = bfs_pkg::SUM_W'(sum_b[col] + b);
        sq_b[col]  = bfs_pkg::SQ_W'(sq_b[col] + int'(b) * int'(b));
      end

      if (x_end && y_end) begin
        n  = (xi + 1) * (yi + 1);
        p1 = longint'(n) * longint'(sq_a[col]);
        q1 = longint'(sum_a[col]) * longint'(sum_a[col]);
        p2 = longint'(n) * longint'(sq_b[col]);
        q2 = longint'(sum_b[col]) * longint'(sum_b[col]);
        v1 = (p1 >= q1) ? p1 - q1 : 0;
        v2 = (p2 >= q2) ? p2 - q2 : 0;
        r.tile_col    = bfs_pkg::TILE_IDX_W'(col);
        r.tile_row    = bfs_pkg::TILE_IDX_W'(row);
        r.pick_second = (v2 >= v1);
        r.frame_done  = row_end && col_end;
        tiles_due.insert(tiles_due.size(), r);
      end

      if (row_end) begin
        pos_x = '0;
        x_in  = '0;
        if (col_end) begin
          pos_y = '0;
          y_in  = '0;
        end else begin
          pos_y = pos_y + 1'b1;
          y_in  = y_end ? 5'd0 : 5'(yi + 1);
        end
      end else begin
        pos_x = pos_x + 1'b1;
        x_in  = x_end ? 5'd0 : 5'(xi + 1);
      end
    endfunction

    function void check_result(bfs_pkg::bfs_result_t got);
      bfs_pkg::bfs_result_t want;
      if (tiles_due.size() == 0) begin
        $error("tile result with nothing expected: col %0d row %0d",
               got.tile_col, got.tile_row);
        errors++;
        return;
      end
      want = tiles_due.pop_front();
      if (got.tile_col !== want.tile_col) begin
        $error("tile_col: expected %0d, got %0d", want.tile_col, got.tile_col);
        errors++;
      end
      if (got.tile_row !== want.tile_row) begin
        $error("tile_row: expected %0d, got %0d", want.tile_row, got.tile_row);
        errors++;
      end
      if (got.pick_second !== want.pick_second) begin
        $error("pick_second: expected %0d, got %0d", want.pick_second, got.pick_second);
        errors++;
      end
      if (got.frame_done !== want.frame_done) begin
        $error("frame_done: expected %0d, got %0d", want.frame_done, got.frame_done);
        errors++;
      end
    endfunction

    function int pending();
      return tiles_due.size();
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [bfs_pkg::CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [bfs_pkg::CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  logic [bfs_pkg::PIX_W-1:0]       pixel_first_i = '0;
  logic [bfs_pkg::PIX_W-1:0]       pixel_second_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic [bfs_pkg::TILE_IDX_W-1:0]  tile_col_o;
  logic [bfs_pkg::TILE_IDX_W-1:0]  tile_row_o;
  logic                            pick_second_o;
  logic                            frame_done_o;

  focus_scoreboard      board;
  bit                   no_idle = 1'b0;
  int                   rx_hold = 0;
  bfs_pkg::bfs_result_t seen;
  int                   random_items = 0;

  block_variance_focus_select dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_first_i  (pixel_first_i),
    .pixel_second_i (pixel_second_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .tile_col_o     (tile_col_o),
    .tile_row_o     (tile_row_o),
    .pick_second_o  (pick_second_o),
    .frame_done_o   (frame_done_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Result side: check each transfer, then hold ready low for a drawn stall.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        seen.tile_col    = tile_col_o;
        seen.tile_row    = tile_row_o;
        seen.pick_second = pick_second_o;
        seen.frame_done  = frame_done_o;
        board.check_result(seen);
        rx_hold = no_idle ? 0 : $urandom_range(0, 5);
        out_ready_i <= (rx_hold == 0);
      end else if (!out_ready_i) begin
        if (rx_hold > 0) rx_hold = rx_hold - 1;
        if (rx_hold == 0) out_ready_i <= 1'b1;
      end
    end
  end

  // Keep cfg_valid_i high; callers lower it after the last write of a batch.
  task automatic write_reg(logic [bfs_pkg::CFG_IDX_W-1:0] idx,
                           logic [bfs_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, data);
  endtask

  task automatic configure(logic [bfs_pkg::CFG_DATA_W-1:0] tile_data,
                           logic [bfs_pkg::CFG_DATA_W-1:0] width_data,
                           logic [bfs_pkg::CFG_DATA_W-1:0] height_data);
    write_reg(bfs_pkg::CFG_TILE_SIZE, tile_data);
    write_reg(bfs_pkg::CFG_IMAGE_WIDTH, width_data);
    write_reg(bfs_pkg::CFG_IMAGE_HEIGHT, height_data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Valid stays high across back-to-back transfers; it drops only for a gap or a drain wait.
  task automatic send_pixel(logic [bfs_pkg::PIX_W-1:0] a, logic [bfs_pkg::PIX_W-1:0] b,
                            bit hold_for_drain);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0 || hold_for_drain) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      if (hold_for_drain) begin
        wait_drained();
        @(posedge clk_i);
      end
    end
    in_valid_i     <= 1'b1;
    pixel_first_i  <= a;
    pixel_second_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_pixel(a, b);
  endtask

  // Drop valid and let the block settle before any register write.
  task automatic end_burst();
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (DRAIN) @(posedge clk_i);
  endtask

  function automatic void next_pair(pix_style_e style, logic [bfs_pkg::PIX_W-1:0] base_a,
                                    logic [bfs_pkg::PIX_W-1:0] base_b,
                                    output logic [bfs_pkg::PIX_W-1:0] a,
                                    output logic [bfs_pkg::PIX_W-1:0] b);
    int d;
    a = bfs_pkg::PIX_W'($urandom_range(0, 255));
    b = bfs_pkg::PIX_W'($urandom_range(0, 255));
    case (style)
      PIX_FIRST_FLAT: a = base_a;
      PIX_BOTH_FLAT: begin
        a = base_a;
        b = base_b;
      end
      PIX_EXTREMES: begin
        a = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      PIX_EQUAL: b = a;
      PIX_NEAR: begin
        d = int'(base_a) + $urandom_range(0, 3);
        a = bfs_pkg::PIX_W'(d);
        d = int'(base_a) + $urandom_range(0, 3);
        b = bfs_pkg::PIX_W'(d);
      end
      default: ;
    endcase
  endfunction

  task automatic run_phase(logic [bfs_pkg::CFG_DATA_W-1:0] tile_data,
                           logic [bfs_pkg::CFG_DATA_W-1:0] width_data,
                           logic [bfs_pkg::CFG_DATA_W-1:0] height_data, int count);
    pix_style_e                style;
    logic [bfs_pkg::PIX_W-1:0] base_a, base_b, a, b;
    configure(tile_data, width_data, height_data);
    style   = pix_style_e'($urandom_range(0, 5));
    base_a  = bfs_pkg::PIX_W'($urandom_range(0, 255));
    base_b  = bfs_pkg::PIX_W'($urandom_range(0, 255));
    no_idle = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) != 0) style = style;
      else if ($urandom_range(0, 9) == 0) style = pix_style_e'($urandom_range(0, 5));
      next_pair(style, base_a, base_b, a, b);
      send_pixel(a, b, $urandom_range(0, 39) == 0);
    end
    end_burst();
    no_idle = 1'b0;
    random_items += count;
  endtask

  initial begin
    logic [bfs_pkg::CFG_DATA_W-1:0] td, wd, hd;
    board = new();
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: no tile closes in two pixels.
    send_pixel(8'h00, 8'h00, 1'b0);
    send_pixel(8'hFF, 8'hFF, 1'b0);
    end_burst();

    // 3x3 frame with 2x2 tiles: clipped right and bottom tiles, then wrap.
    configure(11'd2, 11'd3, 11'd3);
    send_pixel(8'hFF, 8'h00, 1'b0);
    send_pixel(8'h00, 8'hFF, 1'b0);
    send_pixel(8'hFF, 8'hFF, 1'b0);
    send_pixel(8'h00, 8'h00, 1'b0);
    send_pixel(8'hFF, 8'h00, 1'b0);
    send_pixel(8'h80, 8'h7F, 1'b0);
    send_pixel(8'h00, 8'hFF, 1'b0);
    send_pixel(8'h01, 8'hFE, 1'b0);
    send_pixel(8'hFF, 8'hFF, 1'b0);
    send_pixel(8'h07, 8'hC8, 1'b0);
    send_pixel(8'hC8, 8'h07, 1'b0);
    send_pixel(8'h40, 8'h40, 1'b0);
    end_burst();

    // Write to an unused index mid-frame: restart with stale sums kept.
    write_reg(CFG_UNUSED_IDX, 11'h7FF);
    cfg_valid_i <= 1'b0;
    for (int i = 0; i < 9; i++) begin
      send_pixel(bfs_pkg::PIX_W'($urandom_range(0, 255)),
                 bfs_pkg::PIX_W'($urandom_range(0, 255)), 1'b0);
    end
    end_burst();

    // Zero tile, width and height all act as one: each pixel ends the frame.
    configure(11'h7C0, 11'd0, 11'd0);
    send_pixel(8'h12, 8'h34, 1'b0);
    send_pixel(8'hFF, 8'h00, 1'b1);
    send_pixel(8'h00, 8'hFF, 1'b0);
    end_burst();

    // Oversized tile saturates; full-height limit; wide single-pixel tiles.
    run_phase(11'd63, 11'd32, 11'd2, 64);
    run_phase(11'd32, 11'd1, 11'd1024, 40);
    run_phase({5'h1F, 6'd1}, 11'd300, 11'h7FF, 300);

    random_items = 0;
    while (random_items < 200) begin
      case ($urandom_range(0, 9))
        0:       td = {5'($urandom_range(0, 31)), 6'd0};
        1:       td = {5'($urandom_range(0, 31)), 6'($urandom_range(33, 63))};
        2:       td = 11'd32;
        default: td = {5'($urandom_range(0, 31)), 6'($urandom_range(1, 6))};
      endcase
      case ($urandom_range(0, 9))
        0:       wd = 11'd0;
        1:       wd = bfs_pkg::CFG_DATA_W'($urandom_range(1025, 2047));
        default: wd = bfs_pkg::CFG_DATA_W'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 9))
        0:       hd = 11'd0;
        1:       hd = 11'd1024;
        default: hd = bfs_pkg::CFG_DATA_W'($urandom_range(1, 12));
      endcase
      run_phase(td, wd, hd, $urandom_range(10, 60));
    end

    if (board.pending() != 0) begin
      $error("%0d tile results never arrived", board.pending());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### sim.f
hw/rtl/bfs_pkg.sv
hw/rtl/bfs_ram.sv
hw/rtl/bfs_front.sv
hw/rtl/bfs_queue.sv
hw/rtl/bfs_back.sv
hw/rtl/block_variance_focus_select.sv
sim/tb.sv
